// ----- hdl/cwr_pkg.sv -----
// ----------------------------------------------------------------------------
// cwr_pkg
// Shared types and constants for the GOIHW to blocked 4x4 weight reorder.
// ----------------------------------------------------------------------------
package cwr_pkg;

    // Register field widths
    localparam int GC_W       = 11;
    localparam int CH_W       = 13;
    localparam int K_W        = 7;

    // Position counter widths
    localparam int GPOS_W     = 10;
    localparam int CPOS_W     = 12;
    localparam int KPOS_W     = 6;

    // Rounded-up tile counts per group, and the narrow multiplier operand
    localparam int TILES_W    = CH_W - 1;
    localparam int MUL_A_W    = 12;

    // Kernel plane position, row * cols + col
    localparam int RC_W       = KPOS_W + K_W;

    localparam int CFG_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int PORT_W     = 32;

    // Tile geometry
    localparam int TILE_ELEMS = 16;
    localparam int TILE_SIDE  = 4;
    localparam int SIDE_MASK  = 3;
    localparam int TILE_SHIFT = 4;

    // Register reset values
    localparam int GROUP_COUNT_RST  = 1;
    localparam int IN_CHANNELS_RST  = 4;
    localparam int OUT_CHANNELS_RST = 4;
    localparam int KERNEL_ROWS_RST  = 1;
    localparam int KERNEL_COLS_RST  = 1;
    localparam int TRANSPOSE_RST    = 0;

    typedef enum logic [2:0] {
        REG_GROUP_COUNT  = 3'd0,
        REG_IN_CHANNELS  = 3'd1,
        REG_OUT_CHANNELS = 3'd2,
        REG_KERNEL_ROWS  = 3'd3,
        REG_KERNEL_COLS  = 3'd4,
        REG_TRANSPOSE    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [GC_W-1:0] group_count;
        logic [CH_W-1:0] in_channels;
        logic [CH_W-1:0] out_channels;
        logic [K_W-1:0]  kernel_rows;
        logic [K_W-1:0]  kernel_cols;
        logic            transpose_mode;
    } cfg_t;

    // outer is the out channel, or the in channel in transpose mode
    typedef struct packed {
        logic [GPOS_W-1:0] group_pos;
        logic [CPOS_W-1:0] outer_chan_pos;
        logic [CPOS_W-1:0] inner_chan_pos;
        logic [KPOS_W-1:0] row_pos;
        logic [KPOS_W-1:0] col_pos;
    } pos_t;

    typedef struct packed {
        logic busy;       // geometry recompute in progress
        logic empty;      // some extent is zero: items give no result
        logic seed_load;  // index terms are ready to reload
    } geom_ctl_t;

endpackage

// ----- hdl/cwr_geom.sv -----
// ----------------------------------------------------------------------------
// cwr_geom
// Recomputes the layout strides after a register write: per-group channel
// counts on a shared restoring divider, then plane, tile and group strides and
// the index terms of the current position on a shared narrow multiplier.
// ----------------------------------------------------------------------------
module cwr_geom #(
    parameter int INDEX_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  cwr_pkg::cfg_t               cfg,
    input  cwr_pkg::pos_t               pos,
    output cwr_pkg::geom_ctl_t          ctl,
    output logic [cwr_pkg::CH_W-1:0]    goc,
    output logic [cwr_pkg::CH_W-1:0]    gic,
    output logic [INDEX_BITS-1:0]       group_stride,
    output logic [INDEX_BITS-1:0]       o_wrap_step,
    output logic [INDEX_BITS-1:0]       i_wrap_step,
    output logic [INDEX_BITS-1:0]       gterm_seed,
    output logic [INDEX_BITS-1:0]       outer_seed,
    output logic [INDEX_BITS-1:0]       inner_seed
);
    import cwr_pkg::*;

    localparam int IW = INDEX_BITS;

    localparam int GOC_RST     = OUT_CHANNELS_RST / GROUP_COUNT_RST;
    localparam int GIC_RST     = IN_CHANNELS_RST / GROUP_COUNT_RST;
    localparam int PLANE_RST   = KERNEL_ROWS_RST * KERNEL_COLS_RST * TILE_ELEMS;
    localparam int TILE_RST    = ((GIC_RST + SIDE_MASK) / TILE_SIDE) * PLANE_RST;
    localparam int GSTRIDE_RST = ((GOC_RST + SIDE_MASK) / TILE_SIDE) * TILE_RST;
    localparam int ROW_WRAP    = SIDE_MASK * TILE_SIDE;

    localparam logic [3:0] DIV_LAST = 4'(CH_W - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_DIV_O,
        S_DIV_I,
        S_PLANE,
        S_TILE,
        S_GSTRIDE,
        S_GTERM,
        S_OTERM,
        S_ITERM,
        S_STEPS
    } state_t;

    state_t              state_reg;
    logic [CH_W-1:0]     num_reg;
    logic [GC_W-1:0]     rem_reg;
    logic [3:0]          cnt_reg;
    logic [CH_W-1:0]     goc_reg;
    logic [CH_W-1:0]     gic_reg;
    logic [IW-1:0]       plane_reg;
    logic [IW-1:0]       tile_reg;
    logic [IW-1:0]       gstride_reg;
    logic [IW-1:0]       o_wrap_reg;
    logic [IW-1:0]       i_wrap_reg;
    logic [IW-1:0]       gseed_reg;
    logic [IW-1:0]       oseed_reg;
    logic [IW-1:0]       iseed_reg;
    logic                empty_reg;

    // restoring divider step
    logic [GC_W:0]       trial;
    logic [GC_W:0]       diff;
    logic                qbit;
    logic [GC_W-1:0]     rem_step;
    logic [CH_W-1:0]     num_step;

    logic [CH_W:0]       goc_round;
    logic [CH_W:0]       gic_round;
    logic [TILES_W-1:0]  goc4;
    logic [TILES_W-1:0]  gic4;

    logic [MUL_A_W-1:0]  mul_a;
    logic [IW-1:0]       mul_b;
    logic [IW-1:0]       prod;
    logic [IW-1:0]       outer_lane;
    logic [IW-1:0]       inner_lane;

    always_comb
    begin
        trial    = {rem_reg, num_reg[CH_W-1]};
        diff     = trial - {1'b0, cfg.group_count};
        qbit     = (trial >= {1'b0, cfg.group_count});
        rem_step = qbit ? diff[GC_W-1:0] : trial[GC_W-1:0];
        num_step = {num_reg[CH_W-2:0], qbit};
    end

    assign goc_round = {1'b0, goc_reg} + (CH_W+1)'(SIDE_MASK);
    assign gic_round = {1'b0, gic_reg} + (CH_W+1)'(SIDE_MASK);
    assign goc4      = goc_round[CH_W:2];
    assign gic4      = gic_round[CH_W:2];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PLANE:
            begin
                mul_a = MUL_A_W'(cfg.kernel_rows);
                mul_b = IW'(cfg.kernel_cols) << TILE_SHIFT;
            end
            S_TILE:
            begin
                mul_a = MUL_A_W'(gic4);
                mul_b = plane_reg;
            end
            S_GSTRIDE:
            begin
                mul_a = MUL_A_W'(goc4);
                mul_b = tile_reg;
            end
            S_GTERM:
            begin
                mul_a = MUL_A_W'(pos.group_pos);
                mul_b = gstride_reg;
            end
            S_OTERM:
            begin
                mul_a = MUL_A_W'(pos.outer_chan_pos[CPOS_W-1:2]);
                mul_b = cfg.transpose_mode ? plane_reg : tile_reg;
            end
            S_ITERM:
            begin
                mul_a = MUL_A_W'(pos.inner_chan_pos[CPOS_W-1:2]);
                mul_b = cfg.transpose_mode ? tile_reg : plane_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = IW'(mul_a * mul_b);

    // offset inside the tile: out lane counts by 4, in lane by 1
    assign outer_lane = cfg.transpose_mode ? IW'(pos.outer_chan_pos[1:0])
                                           : IW'({pos.outer_chan_pos[1:0], 2'b00});
    assign inner_lane = cfg.transpose_mode ? IW'({pos.inner_chan_pos[1:0], 2'b00})
                                           : IW'(pos.inner_chan_pos[1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            num_reg     <= '0;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            goc_reg     <= CH_W'(GOC_RST);
            gic_reg     <= CH_W'(GIC_RST);
            plane_reg   <= IW'(PLANE_RST);
            tile_reg    <= IW'(TILE_RST);
            gstride_reg <= IW'(GSTRIDE_RST);
            o_wrap_reg  <= IW'(TILE_RST - ROW_WRAP);
            i_wrap_reg  <= IW'(PLANE_RST - SIDE_MASK);
            gseed_reg   <= '0;
            oseed_reg   <= '0;
            iseed_reg   <= '0;
            empty_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                end
                S_LOAD:
                begin
                    if (cfg.group_count == '0)
                    begin
                        goc_reg   <= '0;
                        gic_reg   <= '0;
                        state_reg <= S_PLANE;
                    end
                    else
                    begin
                        num_reg   <= cfg.out_channels;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV_O;
                    end
                end
                S_DIV_O:
                begin
                    num_reg <= num_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        goc_reg   <= num_step;
                        num_reg   <= cfg.in_channels;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV_I;
                    end
                end
                S_DIV_I:
                begin
                    num_reg <= num_step;
                    rem_reg <= rem_step;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == DIV_LAST)
                    begin
                        gic_reg   <= num_step;
                        state_reg <= S_PLANE;
                    end
                end
                S_PLANE:
                begin
                    plane_reg <= prod;
                    state_reg <= S_TILE;
                end
                S_TILE:
                begin
                    tile_reg  <= prod;
                    state_reg <= S_GSTRIDE;
                end
                S_GSTRIDE:
                begin
                    gstride_reg <= prod;
                    state_reg   <= S_GTERM;
                end
                S_GTERM:
                begin
                    gseed_reg <= prod;
                    state_reg <= S_OTERM;
                end
                S_OTERM:
                begin
                    oseed_reg <= prod + outer_lane;
                    state_reg <= S_ITERM;
                end
                S_ITERM:
                begin
                    iseed_reg <= prod + inner_lane;
                    state_reg <= S_STEPS;
                end
                S_STEPS:
                begin
                    o_wrap_reg <= tile_reg - IW'(ROW_WRAP);
                    i_wrap_reg <= plane_reg - IW'(SIDE_MASK);
                    empty_reg  <= (cfg.group_count == '0) || (goc_reg == '0) ||
                                  (gic_reg == '0) || (cfg.kernel_rows == '0) ||
                                  (cfg.kernel_cols == '0);
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign ctl.busy      = (state_reg != S_IDLE);
    assign ctl.empty     = empty_reg;
    assign ctl.seed_load = (state_reg == S_STEPS);

    assign goc          = goc_reg;
    assign gic          = gic_reg;
    assign group_stride = gstride_reg;
    assign o_wrap_step  = o_wrap_reg;
    assign i_wrap_step  = i_wrap_reg;
    assign gterm_seed   = gseed_reg;
    assign outer_seed   = oseed_reg;
    assign inner_seed   = iseed_reg;

endmodule

// ----- hdl/conv_weight_reorder_goihw16_core.sv -----
// ----------------------------------------------------------------------------
// conv_weight_reorder_goihw16_core
// Streams convolution weights in GOIHW (or GIOHW) order and tags each word
// with its index in the blocked [g][o/4][i/4][h][w][4x4] layout.
// ----------------------------------------------------------------------------
// One weight word is taken per clock and its result appears in the output
// register on the next clock; the input stalls while that register holds a
// word that the sink is stalling and while the geometry is recomputed. The
// destination index is the sum of running terms for group, out channel and in
// channel kept alongside the position counters, so each word costs one add per
// term. After every register write the input stalls while the per-group
// channel counts pass through one shared 13-step restoring divider (skipped
// when the group count is zero) and the strides and the terms of the current
// position go through one shared 12 by INDEX_BITS multiplier.
// Out of reset the block is ready at once with the reset geometry.
module conv_weight_reorder_goihw16_core #(
    parameter int DATA_BITS  = 32,
    parameter int INDEX_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cwr_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cwr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [cwr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             weight_valid,
    output logic                             weight_stall,
    input  logic [cwr_pkg::PORT_W-1:0]       weight_value,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [cwr_pkg::PORT_W-1:0]       dest_index,
    output logic [cwr_pkg::PORT_W-1:0]       value_out,
    output logic                             tensor_done
);
    import cwr_pkg::*;

    localparam int IW = INDEX_BITS;
    localparam logic [PORT_W-1:0] DATA_MASK = PORT_W'((64'd1 << DATA_BITS) - 64'd1);

    cfg_t               cfg_reg;
    pos_t               pos_reg;
    pos_t               pos_next;
    logic [IW-1:0]      gterm_reg;
    logic [IW-1:0]      oterm_reg;
    logic [IW-1:0]      iterm_reg;
    logic [IW-1:0]      gterm_next;
    logic [IW-1:0]      oterm_next;
    logic [IW-1:0]      iterm_next;

    logic               rvalid_reg;
    logic [PORT_W-1:0]  dest_reg;
    logic [PORT_W-1:0]  value_reg;
    logic               done_reg;

    geom_ctl_t          gctl;
    logic [CH_W-1:0]    goc;
    logic [CH_W-1:0]    gic;
    logic [IW-1:0]      group_stride;
    logic [IW-1:0]      o_wrap_step;
    logic [IW-1:0]      i_wrap_step;
    logic [IW-1:0]      gterm_seed;
    logic [IW-1:0]      outer_seed;
    logic [IW-1:0]      inner_seed;

    logic               cfg_write;
    cfg_reg_t           cfg_sel;
    logic               take;
    logic               fire;

    logic [KPOS_W:0]    col_inc;
    logic [KPOS_W:0]    row_inc;
    logic [CPOS_W:0]    inner_inc;
    logic [CPOS_W:0]    outer_inc;
    logic [GPOS_W:0]    group_inc;
    logic [CH_W-1:0]    inner_ext;
    logic [CH_W-1:0]    outer_ext;
    logic               col_carry;
    logic               row_carry;
    logic               inner_carry;
    logic               outer_carry;
    logic               group_carry;
    logic [IW-1:0]      inner_step;
    logic [IW-1:0]      outer_step;
    logic [RC_W-1:0]    rc;
    logic [IW-1:0]      idx;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.group_count    <= GC_W'(GROUP_COUNT_RST);
            cfg_reg.in_channels    <= CH_W'(IN_CHANNELS_RST);
            cfg_reg.out_channels   <= CH_W'(OUT_CHANNELS_RST);
            cfg_reg.kernel_rows    <= K_W'(KERNEL_ROWS_RST);
            cfg_reg.kernel_cols    <= K_W'(KERNEL_COLS_RST);
            cfg_reg.transpose_mode <= 1'(TRANSPOSE_RST);
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_GROUP_COUNT:  cfg_reg.group_count    <= pwdata[GC_W-1:0];
                REG_IN_CHANNELS:  cfg_reg.in_channels    <= pwdata[CH_W-1:0];
                REG_OUT_CHANNELS: cfg_reg.out_channels   <= pwdata[CH_W-1:0];
                REG_KERNEL_ROWS:  cfg_reg.kernel_rows    <= pwdata[K_W-1:0];
                REG_KERNEL_COLS:  cfg_reg.kernel_cols    <= pwdata[K_W-1:0];
                REG_TRANSPOSE:    cfg_reg.transpose_mode <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            REG_GROUP_COUNT:  prdata = APB_DATA_W'(cfg_reg.group_count);
            REG_IN_CHANNELS:  prdata = APB_DATA_W'(cfg_reg.in_channels);
            REG_OUT_CHANNELS: prdata = APB_DATA_W'(cfg_reg.out_channels);
            REG_KERNEL_ROWS:  prdata = APB_DATA_W'(cfg_reg.kernel_rows);
            REG_KERNEL_COLS:  prdata = APB_DATA_W'(cfg_reg.kernel_cols);
            REG_TRANSPOSE:    prdata = APB_DATA_W'(cfg_reg.transpose_mode);
            default:          prdata = '0;
        endcase
    end

    // ---------------- geometry ----------------
    cwr_geom #(
        .INDEX_BITS (INDEX_BITS)
    ) u_geom (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg          (cfg_reg),
        .pos          (pos_reg),
        .ctl          (gctl),
        .goc          (goc),
        .gic          (gic),
        .group_stride (group_stride),
        .o_wrap_step  (o_wrap_step),
        .i_wrap_step  (i_wrap_step),
        .gterm_seed   (gterm_seed),
        .outer_seed   (outer_seed),
        .inner_seed   (inner_seed)
    );

    // ---------------- handshake ----------------
    assign weight_stall = gctl.busy || (rvalid_reg && result_stall);
    assign take         = weight_valid && !weight_stall;
    assign fire         = take && !gctl.empty;

    // ---------------- position walk ----------------
    assign inner_ext = cfg_reg.transpose_mode ? goc : gic;
    assign outer_ext = cfg_reg.transpose_mode ? gic : goc;

    always_comb
    begin
        col_inc   = {1'b0, pos_reg.col_pos} + 1'b1;
        row_inc   = {1'b0, pos_reg.row_pos} + 1'b1;
        inner_inc = {1'b0, pos_reg.inner_chan_pos} + 1'b1;
        outer_inc = {1'b0, pos_reg.outer_chan_pos} + 1'b1;
        group_inc = {1'b0, pos_reg.group_pos} + 1'b1;

        // a counter at or past its extent wraps and carries
        col_carry   = (col_inc >= cfg_reg.kernel_cols);
        row_carry   = col_carry && (row_inc >= cfg_reg.kernel_rows);
        inner_carry = row_carry && ((CH_W)'(inner_inc) >= inner_ext);
        outer_carry = inner_carry && ((CH_W)'(outer_inc) >= outer_ext);
        group_carry = outer_carry && (group_inc >= cfg_reg.group_count);

        pos_next = pos_reg;
        pos_next.col_pos = col_carry ? '0 : col_inc[KPOS_W-1:0];
        if (col_carry)
            pos_next.row_pos = row_carry ? '0 : row_inc[KPOS_W-1:0];
        if (row_carry)
            pos_next.inner_chan_pos = inner_carry ? '0 : inner_inc[CPOS_W-1:0];
        if (inner_carry)
            pos_next.outer_chan_pos = outer_carry ? '0 : outer_inc[CPOS_W-1:0];
        if (outer_carry)
            pos_next.group_pos = group_carry ? '0 : group_inc[GPOS_W-1:0];
    end

    // term step: lane step inside a tile, or jump to the next tile
    always_comb
    begin
        if (pos_reg.inner_chan_pos[1:0] == 2'(SIDE_MASK))
            inner_step = cfg_reg.transpose_mode ? o_wrap_step : i_wrap_step;
        else
            inner_step = cfg_reg.transpose_mode ? IW'(TILE_SIDE) : IW'(1);

        if (pos_reg.outer_chan_pos[1:0] == 2'(SIDE_MASK))
            outer_step = cfg_reg.transpose_mode ? i_wrap_step : o_wrap_step;
        else
            outer_step = cfg_reg.transpose_mode ? IW'(1) : IW'(TILE_SIDE);
    end

    always_comb
    begin
        gterm_next = gterm_reg;
        oterm_next = oterm_reg;
        iterm_next = iterm_reg;
        if (row_carry)
            iterm_next = (pos_next.inner_chan_pos == '0) ? '0 : iterm_reg + inner_step;
        if (inner_carry)
            oterm_next = (pos_next.outer_chan_pos == '0) ? '0 : oterm_reg + outer_step;
        if (outer_carry)
            gterm_next = (pos_next.group_pos == '0) ? '0 : gterm_reg + group_stride;
    end

    assign rc  = RC_W'(pos_reg.row_pos * cfg_reg.kernel_cols) + RC_W'(pos_reg.col_pos);
    assign idx = gterm_reg + oterm_reg + iterm_reg + (IW'(rc) << TILE_SHIFT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            gterm_reg <= '0;
            oterm_reg <= '0;
            iterm_reg <= '0;
        end
        else if (gctl.seed_load)
        begin
            gterm_reg <= gterm_seed;
            oterm_reg <= outer_seed;
            iterm_reg <= inner_seed;
        end
        else if (fire)
        begin
            pos_reg   <= pos_next;
            gterm_reg <= gterm_next;
            oterm_reg <= oterm_next;
            iterm_reg <= iterm_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvalid_reg <= 1'b0;
        else if (fire)
            rvalid_reg <= 1'b1;
        else if (!result_stall)
            rvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            dest_reg  <= PORT_W'(idx);
            value_reg <= weight_value & DATA_MASK;
            done_reg  <= group_carry;
        end
    end

    assign result_valid = rvalid_reg;
    assign dest_index   = dest_reg;
    assign value_out    = value_reg;
    assign tensor_done  = done_reg;

endmodule

// ----- hdl/cwr_checker.sv -----
// ----------------------------------------------------------------------------
// cwr_checker
// Port-level checks for the weight reorder core, bound to the top level.
// ----------------------------------------------------------------------------
module cwr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             psel,
    input logic                             penable,
    input logic                             pwrite,
    input logic [cwr_pkg::CFG_ADDR_W-1:0]   paddr,
    input logic [cwr_pkg::APB_DATA_W-1:0]   pwdata,
    input logic [cwr_pkg::APB_DATA_W-1:0]   prdata,
    input logic                             pready,
    input logic                             weight_valid,
    input logic                             weight_stall,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic [cwr_pkg::PORT_W-1:0]       dest_index,
    input logic [cwr_pkg::PORT_W-1:0]       value_out,
    input logic                             tensor_done
);
    import cwr_pkg::*;

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            result_valid && $stable(dest_index) && $stable(value_out) &&
            $stable(tensor_done))
        else $error("stalled result word changed");

    // a new result word only follows an accepted weight word
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(weight_valid && !weight_stall))
        else $error("result word without accepted input");

    // strides are rebuilt after a register write, input must hold off
    a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=> weight_stall)
        else $error("input not stalled after register write");

    // a group count write is seen in the readback of that register
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready &&
            (paddr[CFG_ADDR_W-1:2] == REG_GROUP_COUNT) ##1
            (paddr[CFG_ADDR_W-1:2] == REG_GROUP_COUNT) |->
            prdata == APB_DATA_W'($past(pwdata[GC_W-1:0])))
        else $error("group count readback mismatch");

endmodule

bind conv_weight_reorder_goihw16_core cwr_checker u_cwr_checker (.*);
